// ===== rtl/gtcm_pkg.sv =====
package gtcm_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ROW_W        = 64;
    localparam int VTX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int ENT_W        = 13;
    localparam int DECL_W       = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int POP_W        = 4;
    localparam int LANES        = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECLARED_EDGES = 2'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_PICK,
        ST_SCAN,
        ST_CHECK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic pick;
        logic scan;
        logic check;
    } t_cmd;

    typedef struct packed {
        logic pending_none;
    } t_status;

    function automatic logic [VTX_W-1:0] lowest_index(input logic [ROW_W-1:0] x);
        logic [VTX_W-1:0] idx;
        idx = '0;
        for (int k = ROW_W - 1; k >= 0; k--) begin
            if (x[k]) begin
                idx = VTX_W'(k);
            end
        end
        return idx;
    endfunction

    function automatic logic [POP_W-1:0] pop8(input logic [7:0] x);
        logic [POP_W-1:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + POP_W'(x[k]);
        end
        return n;
    endfunction

endpackage

// ===== rtl/gtcm_ctrl.sv =====
module gtcm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_row,
    input  logic             i_out_stall,
    input  gtcm_pkg::t_status i_status,
    output gtcm_pkg::t_cmd   o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);

    gtcm_pkg::t_state r_state;
    gtcm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gtcm_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gtcm_pkg::ST_LOAD: begin
                if (i_in_valid && i_last_row) begin
                    n_state = gtcm_pkg::ST_START;
                end
            end
            gtcm_pkg::ST_START: begin
                n_state = gtcm_pkg::ST_PICK;
            end
            gtcm_pkg::ST_PICK: begin
                if (i_status.pending_none) begin
                    n_state = gtcm_pkg::ST_CHECK;
                end else begin
                    n_state = gtcm_pkg::ST_SCAN;
                end
            end
            gtcm_pkg::ST_SCAN: begin
                n_state = gtcm_pkg::ST_PICK;
            end
            gtcm_pkg::ST_CHECK: begin
                n_state = gtcm_pkg::ST_OUT;
            end
            gtcm_pkg::ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = gtcm_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = gtcm_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            gtcm_pkg::ST_LOAD: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            gtcm_pkg::ST_START: begin
                o_cmd.start = 1'b1;
            end
            gtcm_pkg::ST_PICK: begin
                o_cmd.pick = !i_status.pending_none;
            end
            gtcm_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            gtcm_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
            end
            gtcm_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/gtcm_dp.sv =====
module gtcm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gtcm_pkg::t_cmd                    i_cmd,
    output gtcm_pkg::t_status                 o_status,
    input  logic                              i_cfg_we,
    input  logic [gtcm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gtcm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [gtcm_pkg::VTX_W-1:0]        i_row_index,
    input  logic [gtcm_pkg::ROW_W-1:0]        i_row_bits,
    output logic                              o_is_tree,
    output logic [gtcm_pkg::CNT_W-1:0]        o_reached_count,
    output logic [gtcm_pkg::ENT_W-1:0]        o_edge_end_count
);

    logic [gtcm_pkg::CNT_W-1:0]  r_vertex_count;
    logic [gtcm_pkg::DECL_W-1:0] r_declared_edges;

    logic [gtcm_pkg::ROW_W-1:0]  r_mem [0:gtcm_pkg::MAX_VERTICES-1];
    logic [gtcm_pkg::ROW_W-1:0]  r_rdata;

    logic [gtcm_pkg::ROW_W-1:0]  r_visited;
    logic [gtcm_pkg::ROW_W-1:0]  r_expanded;
    logic [gtcm_pkg::CNT_W-1:0]  r_vertex_tally;
    logic [gtcm_pkg::ENT_W-1:0]  r_entry_tally;
    logic [gtcm_pkg::POP_W-1:0]  r_part [0:gtcm_pkg::LANES-1];

    logic                        r_is_tree;
    logic [gtcm_pkg::CNT_W-1:0]  r_reached;
    logic [gtcm_pkg::ENT_W-1:0]  r_edges;

    logic [gtcm_pkg::CNT_W-1:0]  eff_n;
    logic [gtcm_pkg::ROW_W-1:0]  cols;
    logic [gtcm_pkg::ROW_W-1:0]  pending;
    logic [gtcm_pkg::VTX_W-1:0]  pick_v;
    logic [gtcm_pkg::ROW_W-1:0]  links;
    logic [gtcm_pkg::CNT_W-1:0]  part_sum;
    logic [gtcm_pkg::ENT_W:0]    entry_sum;
    logic [gtcm_pkg::ENT_W-1:0]  n_entry_tally;
    logic                        tree;

    // Vertex count outside 1..MAX_VERTICES is clamped to the nearest end.
    always_comb begin
        if (r_vertex_count == '0) begin
            eff_n = gtcm_pkg::CNT_W'(1);
        end else if (r_vertex_count > gtcm_pkg::CNT_W'(gtcm_pkg::MAX_VERTICES)) begin
            eff_n = gtcm_pkg::CNT_W'(gtcm_pkg::MAX_VERTICES);
        end else begin
            eff_n = r_vertex_count;
        end
    end

    always_comb begin
        for (int k = 0; k < gtcm_pkg::ROW_W; k++) begin
            cols[k] = (gtcm_pkg::CNT_W'(k) < eff_n);
        end
    end

    assign pending               = r_visited & ~r_expanded;
    assign pick_v                = gtcm_pkg::lowest_index(pending);
    assign o_status.pending_none = (pending == '0);
    assign links                 = r_rdata & cols;

    // Per-byte link counts registered by a scan are folded into the entry tally in the cycle after it.
    always_comb begin
        part_sum = '0;
        for (int j = 0; j < gtcm_pkg::LANES; j++) begin
            part_sum = part_sum + gtcm_pkg::CNT_W'(r_part[j]);
        end
        entry_sum = {1'b0, r_entry_tally} + (gtcm_pkg::ENT_W + 1)'(part_sum);
        if (entry_sum[gtcm_pkg::ENT_W]) begin
            n_entry_tally = '1;
        end else begin
            n_entry_tally = entry_sum[gtcm_pkg::ENT_W-1:0];
        end
    end

    assign tree = (r_vertex_tally == eff_n)
               && (r_entry_tally[gtcm_pkg::ENT_W-1:1] == r_declared_edges)
               && (r_declared_edges == gtcm_pkg::DECL_W'(eff_n - gtcm_pkg::CNT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count   <= gtcm_pkg::CNT_W'(1);
            r_declared_edges <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gtcm_pkg::CFG_VERTEX_COUNT: begin
                    r_vertex_count <= i_cfg_data[gtcm_pkg::CNT_W-1:0];
                end
                gtcm_pkg::CFG_DECLARED_EDGES: begin
                    r_declared_edges <= i_cfg_data[gtcm_pkg::DECL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && ({1'b0, i_row_index} < eff_n)) begin
            r_mem[i_row_index] <= i_row_bits;
        end
        if (i_cmd.pick) begin
            r_rdata <= r_mem[pick_v];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited      <= '0;
            r_expanded     <= '0;
            r_vertex_tally <= '0;
            r_entry_tally  <= '0;
            for (int j = 0; j < gtcm_pkg::LANES; j++) begin
                r_part[j] <= '0;
            end
        end else begin
            for (int j = 0; j < gtcm_pkg::LANES; j++) begin
                r_part[j] <= '0;
            end
            if (i_cmd.start) begin
                r_visited      <= gtcm_pkg::ROW_W'(1);
                r_expanded     <= '0;
                r_vertex_tally <= '0;
                r_entry_tally  <= '0;
            end else begin
                r_entry_tally <= n_entry_tally;
                if (i_cmd.pick) begin
                    r_expanded[pick_v] <= 1'b1;
                    if (r_vertex_tally != '1) begin
                        r_vertex_tally <= r_vertex_tally + gtcm_pkg::CNT_W'(1);
                    end
                end
                if (i_cmd.scan) begin
                    r_visited <= r_visited | links;
                    for (int j = 0; j < gtcm_pkg::LANES; j++) begin
                        r_part[j] <= gtcm_pkg::pop8(links[j*8 +: 8]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_is_tree <= tree;
            r_reached <= r_vertex_tally;
            r_edges   <= r_entry_tally;
        end
    end

    assign o_is_tree        = r_is_tree;
    assign o_reached_count  = r_reached;
    assign o_edge_end_count = r_edges;

endmodule

// ===== rtl/graph_tree_check_matrix_top.sv =====
// Adjacency-matrix tree check.
// Input channel (i_in_valid / o_in_stall): one matrix row per transfer, with
// its row index and a last-row flag. Rows at or above the vertex count are
// dropped. A row without the last-row flag gives no result, and the input
// stays open for the next row. The transfer that carries the last-row flag
// stores its row and starts a walk from vertex 0. Each reached vertex takes
// a pick step, which reads its row from the row memory, then a scan step.
// The number of reached vertices lies in 1..64.
// The input stalls for the whole walk and while the result waits.
// Output channel (o_out_valid / i_out_stall): one transfer carrying is_tree,
// reached_count and edge_end_count. While the receiver stalls, the result
// holds and no new row is taken.
// Configuration: write i_cfg_we with index 0 (vertex count) or 1 (declared
// edges) only while the block is idle.
// Reset (synchronous, active low) sets vertex count to 1, declared edges to
// 0 and returns to loading rows; stored rows are undefined until written.
module graph_tree_check_matrix_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gtcm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gtcm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [gtcm_pkg::VTX_W-1:0]        i_row_index,
    input  logic [gtcm_pkg::ROW_W-1:0]        i_row_bits,
    input  logic                              i_last_row,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_is_tree,
    output logic [gtcm_pkg::CNT_W-1:0]        o_reached_count,
    output logic [gtcm_pkg::ENT_W-1:0]        o_edge_end_count
);

    gtcm_pkg::t_cmd    cmd;
    gtcm_pkg::t_status status;

    gtcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_row  (i_last_row),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    gtcm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_row_index      (i_row_index),
        .i_row_bits       (i_row_bits),
        .o_is_tree        (o_is_tree),
        .o_reached_count  (o_reached_count),
        .o_edge_end_count (o_edge_end_count)
    );

endmodule

// ===== rtl/gtcm_checker.sv =====
module gtcm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           i_last_row,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [gtcm_pkg::CNT_W-1:0]     o_reached_count
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // No row is taken while a result waits.
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // The last row starts the walk, which blocks further input.
    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_row |=> o_in_stall && !o_out_valid)
        else $error("walk did not start after last row");

    // The walk always reaches vertex 0 and never more than the matrix size.
    a_reached_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_reached_count != '0)
            && (o_reached_count <= gtcm_pkg::CNT_W'(gtcm_pkg::MAX_VERTICES)))
        else $error("reached count out of range");

endmodule

bind graph_tree_check_matrix_top gtcm_checker u_gtcm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_last_row      (i_last_row),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_reached_count (o_reached_count)
);
